### hdl/rhh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Robin Hood hash map package
// Shared constants, codes and types for the hash map core and its units.
// ----------------------------------------------------------------------------
package rhh_pkg;

    localparam int unsigned HASH_W      = 32;
    localparam int unsigned COUNT_W     = 10;
    localparam int unsigned IN_TDATA_W  = 104;
    localparam int unsigned OUT_TDATA_W = 48;

    localparam logic [HASH_W-1:0] HASH_LOW = 32'h7FFF_FFFF;
    localparam logic [HASH_W-1:0] TOMB_BIT = 32'h8000_0000;

    localparam logic [COUNT_W-1:0] MAX_ENTRIES_RST = 10'd921;

    localparam logic [1:0] CMD_GET = 2'd0;
    localparam logic [1:0] CMD_SET = 2'd1;
    localparam logic [1:0] CMD_DEL = 2'd2;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_MISS = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HOME,
        ST_FIND_RD,
        ST_FIND_CHK,
        ST_INS_RD,
        ST_INS_CHK,
        ST_DONE
    } rhh_state_t;

    // Outcome of comparing the probing entry against one resident slot.
    typedef struct packed {
        logic empty;   // slot never used
        logic tomb;    // slot holds a deleted entry
        logic match;   // same hash and key as the probing entry
        logic poorer;  // resident sits closer to its home than the prober
    } probe_flags_t;

endpackage

`default_nettype wire

### hdl/robin_hood_hash_map_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Robin Hood hash map core
// Open-addressed map with linear probing, displacement on insert and
// tombstones on delete.
//
// Usage: one command beat enters on s_axis (get, set or delete with key, hash
// and value) and exactly one result beat leaves on m_axis (status, old value,
// replaced flag, live entry count). The user writes the max_entries register
// over cfg_wr_en / cfg_wr_data only while no command is in flight; the core
// does not enforce it. Steps: the idle state accepts the command, the home
// state waits for the home slot, each lookup probe takes a read state and a
// check state, a set of a new key adds a read and a check state per insert
// probe, and the done state posts the result. The registered read of the slot
// memory splits each probe step in two. One command is worked on at a time.
// Reset: all control state clears, max_entries returns to 921, and a clearing
// pass writes every slot empty before s_axis_tready rises.
// Stall: the result sits in an output register; the core accepts and works
// the next command meanwhile and holds its result until the register frees.
// ----------------------------------------------------------------------------
module robin_hood_hash_map_core #(
    parameter int unsigned SLOTS      = 1024,
    parameter int unsigned KEY_BITS   = 32,
    parameter int unsigned VALUE_BITS = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // cmd[1:0], key[33:2], key_hash[65:34], value[97:66], zero fill
    input  wire logic [rhh_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // status[1:0], old_value[33:2], replaced[34], entry_count[44:35], zero fill
    output logic [rhh_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    input  wire logic                               cfg_wr_en,
    input  wire logic [rhh_pkg::COUNT_W-1:0]        cfg_wr_data
);

    localparam int unsigned IW = $clog2(SLOTS);
    localparam int unsigned SW = $clog2(SLOTS + 1);
    localparam int unsigned KW = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int unsigned VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam int unsigned EW = IW + 32 + KW + VW;
    localparam int unsigned CW = rhh_pkg::COUNT_W;

    rhh_pkg::rhh_state_t state_reg, state_next;

    logic [IW-1:0] clr_reg, clr_next;
    logic [1:0]    cmd_reg, cmd_next;
    logic [KW-1:0] key_reg, key_next;
    logic [31:0]   hash_reg, hash_next;
    logic [IW-1:0] home_reg, home_next;
    logic [VW-1:0] val_reg, val_next;
    logic [IW-1:0] pos_reg, pos_next;
    logic [SW-1:0] d_reg, d_next;
    logic [CW-1:0] live_reg, live_next;
    logic [CW-1:0] max_reg, max_next;
    logic [1:0]    rstat_reg, rstat_next;
    logic [31:0]   rold_reg, rold_next;
    logic          rrepl_reg, rrepl_next;
    logic          out_valid_reg, out_valid_next;
    logic [rhh_pkg::OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    logic [31:0]   in_hash_raw;
    logic [31:0]   in_hash;
    logic          accept;
    logic          home_start;
    logic          home_done;
    logic [IW-1:0] home_res;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    logic [VW-1:0] ent_val;
    logic [KW-1:0] ent_key;
    logic [31:0]   ent_hash;
    logic [IW-1:0] ent_home;
    logic [EW-1:0] carry_ent;

    rhh_pkg::probe_flags_t pflags;
    logic [IW-1:0] res_dist;
    logic [IW-1:0] pos_adv;
    logic [SW-1:0] d_inc;
    logic [SW-1:0] r_inc;
    logic          table_full;

    assign accept      = s_axis_tvalid && s_axis_tready;
    assign in_hash_raw = s_axis_tdata[65:34] & rhh_pkg::HASH_LOW;
    assign in_hash     = (in_hash_raw == '0) ? 32'd1 : in_hash_raw;
    assign home_start  = accept;

    assign ent_val   = ram_rdata[VW-1:0];
    assign ent_key   = ram_rdata[VW +: KW];
    assign ent_hash  = ram_rdata[VW+KW +: 32];
    assign ent_home  = ram_rdata[VW+KW+32 +: IW];
    assign carry_ent = {home_reg, hash_reg, key_reg, val_reg};

    assign d_inc = (32'(d_reg) >= 32'(SLOTS)) ? d_reg : d_reg + SW'(1);
    assign r_inc = SW'(res_dist) + SW'(1);
    assign table_full = (live_reg >= max_reg) || (32'(live_reg) >= 32'(SLOTS));

    rhh_slot_ram #(
        .DEPTH (SLOTS),
        .AW    (IW),
        .DW    (EW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rhh_home_unit #(
        .SLOTS (SLOTS),
        .IW    (IW)
    ) u_home (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (home_start),
        .hash_in (in_hash[30:0]),
        .done    (home_done),
        .home    (home_res)
    );

    rhh_probe_unit #(
        .SLOTS (SLOTS),
        .IW    (IW),
        .SW    (SW),
        .KW    (KW)
    ) u_probe (
        .pos        (pos_reg),
        .probe_dist (d_reg),
        .ent_hash   (ent_hash),
        .ent_home   (ent_home),
        .ent_key    (ent_key),
        .cmp_hash   (hash_reg),
        .cmp_key    (key_reg),
        .flags      (pflags),
        .res_dist   (res_dist),
        .pos_next   (pos_adv)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rhh_pkg::ST_CLEAR;
            clr_reg       <= '0;
            live_reg      <= '0;
            max_reg       <= rhh_pkg::MAX_ENTRIES_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            live_reg      <= live_next;
            max_reg       <= max_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        hash_reg     <= hash_next;
        home_reg     <= home_next;
        val_reg      <= val_next;
        pos_reg      <= pos_next;
        d_reg        <= d_next;
        rstat_reg    <= rstat_next;
        rold_reg     <= rold_next;
        rrepl_reg    <= rrepl_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        hash_next      = hash_reg;
        home_next      = home_reg;
        val_next       = val_reg;
        pos_next       = pos_reg;
        d_next         = d_reg;
        live_next      = live_reg;
        max_next       = cfg_wr_en ? cfg_wr_data : max_reg;
        rstat_next     = rstat_reg;
        rold_next      = rold_reg;
        rrepl_next     = rrepl_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        s_axis_tready  = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = pos_reg;
        ram_wdata      = carry_ent;
        ram_raddr      = pos_reg;

        case (state_reg)
            rhh_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + IW'(1);
                if (32'(clr_reg) + 32'd1 == 32'(SLOTS))
                begin
                    clr_next   = '0;
                    state_next = rhh_pkg::ST_IDLE;
                end
            end

            rhh_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd_next   = s_axis_tdata[1:0];
                    key_next   = s_axis_tdata[2 +: KW];
                    hash_next  = in_hash;
                    val_next   = s_axis_tdata[66 +: VW];
                    rstat_next = rhh_pkg::STATUS_OK;
                    rold_next  = '0;
                    rrepl_next = 1'b0;
                    state_next = rhh_pkg::ST_HOME;
                end
            end

            rhh_pkg::ST_HOME:
            begin
                if (home_done)
                begin
                    home_next  = home_res;
                    pos_next   = home_res;
                    d_next     = '0;
                    state_next = rhh_pkg::ST_FIND_RD;
                end
            end

            rhh_pkg::ST_FIND_RD:
            begin
                state_next = rhh_pkg::ST_FIND_CHK;
            end

            rhh_pkg::ST_FIND_CHK:
            begin
                if (pflags.empty || pflags.poorer ||
                    (!pflags.match && (32'(d_reg) + 32'd1 >= 32'(SLOTS))))
                begin
                    // Key is absent.
                    state_next = rhh_pkg::ST_DONE;
                    case (cmd_reg)
                        rhh_pkg::CMD_SET:
                        begin
                            if (table_full)
                            begin
                                rstat_next = rhh_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                live_next  = live_reg + CW'(1);
                                pos_next   = home_reg;
                                d_next     = '0;
                                state_next = rhh_pkg::ST_INS_RD;
                            end
                        end
                        default:
                        begin
                            rstat_next = rhh_pkg::STATUS_MISS;
                        end
                    endcase
                end
                else if (pflags.match)
                begin
                    rold_next  = 32'(ent_val);
                    state_next = rhh_pkg::ST_DONE;
                    case (cmd_reg)
                        rhh_pkg::CMD_SET:
                        begin
                            ram_we     = 1'b1;
                            ram_wdata  = {ent_home, ent_hash, ent_key, val_reg};
                            rrepl_next = 1'b1;
                        end
                        rhh_pkg::CMD_DEL:
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = {ent_home, ent_hash | rhh_pkg::TOMB_BIT,
                                         ent_key, ent_val};
                            if (live_reg != '0)
                            begin
                                live_next = live_reg - CW'(1);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else
                begin
                    pos_next   = pos_adv;
                    d_next     = d_inc;
                    state_next = rhh_pkg::ST_FIND_RD;
                end
            end

            rhh_pkg::ST_INS_RD:
            begin
                state_next = rhh_pkg::ST_INS_CHK;
            end

            rhh_pkg::ST_INS_CHK:
            begin
                pos_next   = pos_adv;
                d_next     = d_inc;
                state_next = rhh_pkg::ST_INS_RD;
                if (pflags.empty || (pflags.poorer && pflags.tomb))
                begin
                    ram_we     = 1'b1;
                    state_next = rhh_pkg::ST_DONE;
                end
                else if (pflags.poorer)
                begin
                    // Swap: the resident leaves and carries on with its own distance.
                    ram_we    = 1'b1;
                    hash_next = ent_hash;
                    home_next = ent_home;
                    key_next  = ent_key;
                    val_next  = ent_val;
                    d_next    = r_inc;
                end
            end

            rhh_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {3'b000, live_reg, rrepl_reg, rold_reg, rstat_reg};
                    state_next     = rhh_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = rhh_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_axis_tready)
        else $error("core took a command while still working the previous one");

    a_live_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        32'(live_reg) <= 32'(SLOTS))
        else $error("live entry count exceeds the table size");

    a_live_step: assert property (@(posedge clk) disable iff (!rst_n)
        (live_reg == $past(live_reg)) || (live_reg == $past(live_reg) + CW'(1)) ||
        (live_reg + CW'(1) == $past(live_reg)))
        else $error("live entry count moved by more than one");

    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[1:0] == rhh_pkg::STATUS_FULL)) |->
        ((m_axis_tdata[33:2] == '0) && !m_axis_tdata[34]))
        else $error("full status carries a value or replaced flag");

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rhh_pkg::ST_CLEAR) |-> !out_valid_reg)
        else $error("result posted during the clearing pass");

endmodule

`default_nettype wire

### hdl/rhh_slot_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Slot memory
// Single write port, single registered read port, one entry per table slot.
// ----------------------------------------------------------------------------
module rhh_slot_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10,
    parameter int unsigned DW    = 106
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hdl/rhh_home_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Home slot unit
// Computes hash mod SLOTS with a reciprocal multiply, a back multiply and one
// correction step through h_reg, prod_reg, qs_reg and home_reg; done marks home.
// ----------------------------------------------------------------------------
module rhh_home_unit #(
    parameter int unsigned SLOTS = 1024,
    parameter int unsigned IW    = 10
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [30:0] hash_in,
    output logic             done,
    output logic [IW-1:0]    home
);

    // floor(2^31 / SLOTS); the estimated quotient is low by at most one.
    localparam logic [31:0] RECIP = 32'((64'd1 << 31) / 64'(SLOTS));

    logic [3:0]  vld_reg;
    logic [30:0] h_reg;
    logic [62:0] prod_reg;
    logic [31:0] qs_reg;
    logic [IW-1:0] home_reg;
    logic [31:0] rem;
    logic [31:0] rem_fix;

    always_comb
    begin
        rem     = {1'b0, h_reg} - qs_reg;
        rem_fix = (rem >= 32'(SLOTS)) ? (rem - 32'(SLOTS)) : rem;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            h_reg <= hash_in;
        end
        prod_reg <= 63'(h_reg) * 63'(RECIP);
        qs_reg   <= 32'(prod_reg[62:31] * 32'(SLOTS));
        home_reg <= rem_fix[IW-1:0];
    end

    assign done = vld_reg[3];
    assign home = home_reg;

endmodule

`default_nettype wire

### hdl/rhh_probe_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Probe unit
// Shared compare and distance logic used at every probe step of lookups and
// inserts: slot state, key match, resident distance and the next position.
// ----------------------------------------------------------------------------
module rhh_probe_unit #(
    parameter int unsigned SLOTS = 1024,
    parameter int unsigned IW    = 10,
    parameter int unsigned SW    = 11,
    parameter int unsigned KW    = 32
) (
    input  wire logic [IW-1:0]          pos,
    input  wire logic [SW-1:0]          probe_dist,
    input  wire logic [31:0]            ent_hash,
    input  wire logic [IW-1:0]          ent_home,
    input  wire logic [KW-1:0]          ent_key,
    input  wire logic [31:0]            cmp_hash,
    input  wire logic [KW-1:0]          cmp_key,
    output rhh_pkg::probe_flags_t       flags,
    output logic [IW-1:0]               res_dist,
    output logic [IW-1:0]               pos_next
);

    logic [IW:0] wrap_pos;

    always_comb
    begin
        // Distance of the resident from its home, modulo the table size.
        if (pos >= ent_home)
        begin
            wrap_pos = {1'b0, pos};
        end
        else
        begin
            wrap_pos = {1'b0, pos} + (IW+1)'(SLOTS);
        end
        res_dist = IW'(wrap_pos - {1'b0, ent_home});

        if (32'(pos) + 32'd1 == 32'(SLOTS))
        begin
            pos_next = '0;
        end
        else
        begin
            pos_next = pos + IW'(1);
        end

        flags.empty  = (ent_hash == '0);
        flags.tomb   = ((ent_hash & rhh_pkg::TOMB_BIT) != '0);
        flags.match  = (ent_hash == cmp_hash) && (ent_key == cmp_key);
        flags.poorer = (32'(res_dist) < 32'(probe_dist));
    end

endmodule

`default_nettype wire

### tb/robin_hood_hash_map_core_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Robin Hood hash map core testbench
// Drives get, set and delete commands into the core through its command
// stream and checks every result beat against a built-in Robin Hood table
// predictor. Commands come as directed corner cases and then random traffic
// on small key pools with clustered hashes. The max_entries limit is changed
// between phases, and both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module robin_hood_hash_map_core_tb;

    localparam int unsigned SLOTS      = 1024;
    localparam int unsigned POOL_SIZE  = 48;
    localparam int unsigned POOL_SPAN  = 40;
    localparam int unsigned QUIET_MAX  = 20000;
    localparam int unsigned HOLD_LEN   = 400;
    localparam int unsigned MAX_SHOWN  = 10;

    // Reserved command code; the core treats it as a get.
    localparam logic [1:0] CMD_RSVD = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] key;
        logic [31:0] key_hash;
        logic [31:0] value;
    } hash_cmd_t;

    typedef struct packed {
        logic [1:0]                  status;
        logic [31:0]                 old_value;
        logic                        replaced;
        logic [rhh_pkg::COUNT_W-1:0] entry_count;
    } hash_rsp_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic [rhh_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [rhh_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [rhh_pkg::COUNT_W-1:0]     cfg_wr_data = '0;

    // Predicted table contents.
    logic [31:0]            tbl_hash [SLOTS];
    logic [31:0]            tbl_key  [SLOTS];
    logic [31:0]            tbl_val  [SLOTS];
    int unsigned            live_cnt;
    int unsigned            max_entries_q;

    hash_cmd_t              cmd_q[$];
    hash_rsp_t              expected_rsp_q[$];
    hash_cmd_t              cur_cmd;
    int unsigned            fail_cnt;

    logic [31:0]            pool_key  [POOL_SIZE];
    logic [31:0]            pool_hash [POOL_SIZE];

    robin_hood_hash_map_core #(
        .SLOTS      (SLOTS),
        .KEY_BITS   (32),
        .VALUE_BITS (32)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Table predictor
    // ------------------------------------------------------------------
    function automatic int unsigned slot_home(logic [31:0] h);
        return (h & rhh_pkg::HASH_LOW) % SLOTS;
    endfunction

    function automatic int unsigned slot_dist(logic [31:0] h, int unsigned pos);
        return (pos + SLOTS - slot_home(h)) % SLOTS;
    endfunction

    function automatic int probe_lookup(logic [31:0] h, logic [31:0] k);
        int unsigned pos;
        pos = slot_home(h);
        for (int unsigned d = 0; d < SLOTS; d++)
        begin
            if (tbl_hash[pos] == '0)
                return -1;
            if (d > slot_dist(tbl_hash[pos], pos))
                return -1;
            if (tbl_hash[pos] == h && tbl_key[pos] == k)
                return int'(pos);
            pos = (pos + 1) % SLOTS;
        end
        return -1;
    endfunction

    // Walks forward from the home slot; a resident closer to its home is
    // swapped out and the carried entry keeps probing with its own distance.
    function automatic void place_new(logic [31:0] h, logic [31:0] k, logic [31:0] v);
        int unsigned pos;
        longint unsigned d;
        longint unsigned limit;
        int unsigned r;
        logic [31:0] th;
        logic [31:0] tk;
        logic [31:0] tv;
        pos = slot_home(h);
        d = 0;
        limit = longint'(SLOTS) * SLOTS + 2 * SLOTS;
        for (longint unsigned n = 0; n < limit; n++)
        begin
            th = tbl_hash[pos];
            if (th == '0)
            begin
                tbl_hash[pos] = h;
                tbl_key[pos]  = k;
                tbl_val[pos]  = v;
                return;
            end
            r = slot_dist(th, pos);
            if (r < d)
            begin
                if ((th & rhh_pkg::TOMB_BIT) != '0)
                begin
                    tbl_hash[pos] = h;
                    tbl_key[pos]  = k;
                    tbl_val[pos]  = v;
                    return;
                end
                tk = tbl_key[pos];
                tv = tbl_val[pos];
                tbl_hash[pos] = h;
                tbl_key[pos]  = k;
                tbl_val[pos]  = v;
                h = th;
                k = tk;
                v = tv;
                d = r;
            end
            pos = (pos + 1) % SLOTS;
            d++;
        end
    endfunction

    function automatic hash_rsp_t hash_map_apply(hash_cmd_t c);
        hash_rsp_t r;
        logic [31:0] h;
        int idx;
        r = '0;
        r.status = rhh_pkg::STATUS_OK;
        h = c.key_hash & rhh_pkg::HASH_LOW;
        if (h == '0)
            h = 32'd1;
        idx = probe_lookup(h, c.key);
        case (c.cmd)
            rhh_pkg::CMD_SET:
            begin
                if (idx >= 0)
                begin
                    r.old_value = tbl_val[idx];
                    r.replaced  = 1'b1;
                    tbl_val[idx] = c.value;
                end
                else if (live_cnt >= max_entries_q || live_cnt >= SLOTS)
                    r.status = rhh_pkg::STATUS_FULL;
                else
                begin
                    place_new(h, c.key, c.value);
                    live_cnt++;
                end
            end
            rhh_pkg::CMD_DEL:
            begin
                if (idx >= 0)
                begin
                    r.old_value = tbl_val[idx];
                    tbl_hash[idx] = tbl_hash[idx] | rhh_pkg::TOMB_BIT;
                    if (live_cnt > 0)
                        live_cnt--;
                end
                else
                    r.status = rhh_pkg::STATUS_MISS;
            end
            default:
            begin
                if (idx >= 0)
                    r.old_value = tbl_val[idx];
                else
                    r.status = rhh_pkg::STATUS_MISS;
            end
        endcase
        r.entry_count = live_cnt[rhh_pkg::COUNT_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Command sender: bursts of random length with random gaps.
    // ------------------------------------------------------------------
    int unsigned burst_left;
    int unsigned gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        logic hold;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            burst_left    = 8;
            gap_left      = 0;
        end
        else
        begin
            hold = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_rsp_q.push_back(hash_map_apply(cur_cmd));
                hold = 1'b0;
            end
            if (!hold)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (cmd_q.size() > 0)
                begin
                    cur_cmd = cmd_q.pop_front();
                    s_axis_tdata <= {{(rhh_pkg::IN_TDATA_W - 98){1'b0}}, cur_cmd.value,
                                     cur_cmd.key_hash, cur_cmd.key, cur_cmd.cmd};
                    s_axis_tvalid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        case ($urandom_range(0, 9))
                            0, 1, 2: gap_left = 0;
                            9:       gap_left = $urandom_range(10, 30);
                            default: gap_left = $urandom_range(1, 6);
                        endcase
                    end
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: changing stall modes plus one long hold-off.
    // ------------------------------------------------------------------
    int unsigned rx_mode;
    int unsigned rx_left;
    int unsigned hold_left;
    int unsigned rx_beats;
    logic        hold_done;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_mode   = 0;
            rx_left   = 50;
            hold_left = 0;
            rx_beats  = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                rx_beats++;
            // Hold off for a long stretch while the sender keeps offering,
            // so the core backs up and drops s_axis_tready.
            if (rx_beats == 200 && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    default: m_axis_tready <= ($urandom_range(0, 7) == 0);
                endcase
                if (rx_left > 0)
                    rx_left--;
                if (rx_left == 0)
                begin
                    rx_mode = $urandom_range(0, 2);
                    rx_left = $urandom_range(1, 200);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        hash_rsp_t got;
        hash_rsp_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status      = m_axis_tdata[1:0];
            got.old_value   = m_axis_tdata[33:2];
            got.replaced    = m_axis_tdata[34];
            got.entry_count = m_axis_tdata[44:35];
            if (expected_rsp_q.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= MAX_SHOWN)
                    $display("ERROR: result beat with none expected: status %0d old %h",
                             got.status, got.old_value);
            end
            else
            begin
                want = expected_rsp_q.pop_front();
                if (got != want)
                begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_SHOWN)
                    begin
                        $display("ERROR: result mismatch: expected status %0d old %h repl %0d count %0d",
                                 want.status, want.old_value, want.replaced,
                                 want.entry_count);
                        $display("       got status %0d old %h repl %0d count %0d",
                                 got.status, got.old_value, got.replaced,
                                 got.entry_count);
                    end
                end
            end
        end
    end

    // Ends the run when neither side moves a beat for too long.
    int unsigned quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_MAX)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic hash_cmd_t mk_cmd(logic [1:0] c, logic [31:0] k,
                                         logic [31:0] h, logic [31:0] v);
        hash_cmd_t r;
        r.cmd      = c;
        r.key      = k;
        r.key_hash = h;
        r.value    = v;
        return r;
    endfunction

    task automatic wait_idle();
        while (cmd_q.size() != 0 || s_axis_tvalid || expected_rsp_q.size() != 0)
            @(negedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_max_entries(logic [rhh_pkg::COUNT_W-1:0] v);
        wait_idle();
        cfg_wr_en     <= 1'b1;
        cfg_wr_data   <= v;
        max_entries_q = v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // Fills a fresh key pool whose homes crowd into one window of the
    // table, then queues mostly pool traffic with some random noise.
    task automatic queue_random_ops(int unsigned n);
        int unsigned base;
        int unsigned sel;
        logic [1:0]  op;
        logic [31:0] h;
        logic [31:0] v;
        base = $urandom_range(0, SLOTS - 1);
        for (int unsigned i = 0; i < POOL_SIZE; i++)
        begin
            pool_key[i] = $urandom;
            h = $urandom;
            h[9:0] = 10'((base + $urandom_range(0, POOL_SPAN - 1)) % SLOTS);
            pool_hash[i] = (i % 8 == 7) ? pool_hash[i-1] : h;
        end
        pool_key[1]  = '0;
        pool_key[2]  = '1;
        pool_hash[0] = '0;
        for (int unsigned i = 0; i < n; i++)
        begin
            v = ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom;
            if ($urandom_range(0, 9) == 0)
                cmd_q.push_back(mk_cmd(2'($urandom_range(0, 3)), $urandom, $urandom, v));
            else
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8: op = rhh_pkg::CMD_SET;
                    9, 10, 11, 12, 13:         op = rhh_pkg::CMD_GET;
                    19:                        op = CMD_RSVD;
                    default:                   op = rhh_pkg::CMD_DEL;
                endcase
                sel = $urandom_range(0, POOL_SIZE - 1);
                h = pool_hash[sel];
                h[31] = 1'($urandom_range(0, 1));
                cmd_q.push_back(mk_cmd(op, pool_key[sel], h, v));
            end
        end
    endtask

    initial
    begin
        fail_cnt      = 0;
        live_cnt      = 0;
        max_entries_q = rhh_pkg::MAX_ENTRIES_RST;
        foreach (tbl_hash[i])
            tbl_hash[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty table, zero hash and value, wrap at the table end,
        // displacement, tombstones, reserved command, hash/key mismatch.
        cmd_q.push_back(mk_cmd(rhh_pkg::CMD_GET, 32'd0,         32'd0,         32'd5));
        cmd_q.push_back(mk_cmd(rhh_pkg::CMD_SET, 32'd0,         32'd0,         32'd0));
        cmd_q.push_back(mk_cmd(rhh_pkg::CMD_GET, 32'd0,         32'h8000_0000, 32'd0));
        cmd_q.push_back(mk_cmd(rhh_pkg::CMD_SET, 32'd0,         32'd1,         32'hFFFF_FFFF));
        cmd_q.push_back(mk_cmd(rhh_pkg::CMD_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1));
        cmd_q.push_back(mk_cmd(rhh_pkg::CMD_SET, 32'd1,         32'h0000_03FF, 32'd11));
        cmd_q.push_back(mk_cmd(rhh_pkg::CMD_SET, 32'd2,         32'h0000_07FF, 32'd22));
        cmd_q.push_back(mk_cmd(rhh_pkg::CMD_GET, 32'd0,         32'd1,         32'd0));
        cmd_q.push_back(mk_cmd(CMD_RSVD,         32'd2,         32'h8000_07FF, 32'd0));
        cmd_q.push_back(mk_cmd(rhh_pkg::CMD_DEL, 32'd1,         32'h0000_03FF, 32'd0));
        cmd_q.push_back(mk_cmd(rhh_pkg::CMD_DEL, 32'd1,         32'h0000_03FF, 32'd0));
        cmd_q.push_back(mk_cmd(rhh_pkg::CMD_GET, 32'd2,         32'h0000_07FF, 32'd0));
        cmd_q.push_back(mk_cmd(rhh_pkg::CMD_SET, 32'd3,         32'h0000_03FF, 32'd33));
        cmd_q.push_back(mk_cmd(rhh_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd0));
        cmd_q.push_back(mk_cmd(rhh_pkg::CMD_DEL, 32'd0,         32'd0,         32'd0));
        cmd_q.push_back(mk_cmd(rhh_pkg::CMD_GET, 32'd2,         32'd5,         32'd0));
        cmd_q.push_back(mk_cmd(CMD_RSVD,         32'd9,         32'd9,         32'd0));
        cmd_q.push_back(mk_cmd(rhh_pkg::CMD_SET, 32'd1,         32'h0000_03FF, 32'd44));
        cmd_q.push_back(mk_cmd(rhh_pkg::CMD_GET, 32'd3,         32'h0000_03FF, 32'd0));
        queue_random_ops(500);

        write_max_entries(10'd1);
        queue_random_ops(200);
        write_max_entries(10'd1023);
        queue_random_ops(500);
        write_max_entries(10'd0);
        queue_random_ops(100);
        write_max_entries(10'd48);
        queue_random_ops(400);
        write_max_entries(10'd921);
        queue_random_ops(100);

        wait_idle();
        repeat (50) @(posedge clk);
        if (fail_cnt == 0 && expected_rsp_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
